// ----- design/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned PRIO_BITS = 8;
  localparam int unsigned DATA_BITS = 16;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic en;
    logic remove;
  } cell_ctrl_t;

endpackage : spq_pkg
`default_nettype wire

// ----- design/stable_priority_queue_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded sorted priority queue built as a chain of DEPTH cells.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries sorted by priority, highest at the head,
// equal priorities in arrival order. Every cell compares its priority with the
// incoming one in parallel and shifts by one place; one operation is accepted
// per cycle, the result sits in an output register, and a new transfer is
// taken whenever that register is empty or being emptied. An insert into a
// full queue reports status FULL and a remove from an empty queue reports
// status EMPTY, both leaving the queue unchanged. No clearing pass is needed
// after reset.
module stable_priority_queue_unit #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH,
  parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS,
  parameter int unsigned DATA_BITS = spq_pkg::DATA_BITS,
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire                  kind_i,
  input  wire  [PRIO_BITS-1:0] priority_req_i,
  input  wire  [DATA_BITS-1:0] payload_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [DATA_BITS-1:0] out_payload_o,
  output logic [PRIO_BITS-1:0] out_priority_o,
  output logic [1:0]           status_o,
  output logic [CNT_W-1:0]     occupancy_o
);

  logic                 accept;
  logic                 is_remove;
  logic                 full;
  logic                 empty;
  spq_pkg::cell_ctrl_t  ctrl;
  spq_pkg::status_e     status_d;

  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q;
  logic [DATA_BITS-1:0] out_payload_q, out_payload_d;
  logic [PRIO_BITS-1:0] out_priority_q, out_priority_d;
  logic [1:0]           status_q;
  logic [CNT_W-1:0]     occupancy_q;

  logic [PRIO_BITS-1:0] prio_w [DEPTH];
  logic [DATA_BITS-1:0] data_w [DEPTH];
  logic                 ge_w   [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_remove  = (spq_pkg::kind_e'(kind_i) == spq_pkg::KIND_REMOVE);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.en     = accept && (is_remove ? !empty : !full);
  assign ctrl.remove = is_remove;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_ge;
    logic [PRIO_BITS-1:0] left_prio;
    logic [DATA_BITS-1:0] left_data;
    logic [PRIO_BITS-1:0] right_prio;
    logic [DATA_BITS-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_ge   = 1'b1;
      assign left_prio = priority_req_i;
      assign left_data = payload_i;
    end else begin : g_body
      assign left_ge   = ge_w[i-1];
      assign left_prio = prio_w[i-1];
      assign left_data = data_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio = prio_w[i];
      assign right_data = data_w[i];
    end else begin : g_mid
      assign right_prio = prio_w[i+1];
      assign right_data = data_w[i+1];
    end

    spq_cell #(
      .PRIO_BITS (PRIO_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_prio_i   (priority_req_i),
      .new_data_i   (payload_i),
      .occupied_i   (CNT_W'(i) < count_q),
      .left_ge_i    (left_ge),
      .left_prio_i  (left_prio),
      .left_data_i  (left_data),
      .right_prio_i (right_prio),
      .right_data_i (right_data),
      .ge_o         (ge_w[i]),
      .prio_o       (prio_w[i]),
      .data_o       (data_w[i])
    );
  end

  always_comb begin
    count_d        = count_q;
    status_d       = spq_pkg::STATUS_DONE;
    out_payload_d  = '0;
    out_priority_d = '0;
    if (is_remove) begin
      if (empty) begin
        status_d = spq_pkg::STATUS_EMPTY;
      end else begin
        out_payload_d  = data_w[0];
        out_priority_d = prio_w[0];
        count_d        = count_q - CNT_W'(1);
      end
    end else begin
      if (full) begin
        status_d = spq_pkg::STATUS_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_payload_q  <= out_payload_d;
      out_priority_q <= out_priority_d;
      status_q       <= status_d;
      occupancy_q    <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_payload_o  = out_payload_q;
  assign out_priority_o = out_priority_q;
  assign status_o       = status_q;
  assign occupancy_o    = occupancy_q;

endmodule : stable_priority_queue_unit
`default_nettype wire

// ----- design/spq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a priority and a payload, and on an
// operation keeps its entry, takes the new one or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS,
  parameter int unsigned DATA_BITS = spq_pkg::DATA_BITS
) (
  input  wire                     clk_i,
  input  spq_pkg::cell_ctrl_t     ctrl_i,
  input  wire  [PRIO_BITS-1:0]    new_prio_i,
  input  wire  [DATA_BITS-1:0]    new_data_i,
  input  wire                     occupied_i,
  input  wire                     left_ge_i,
  input  wire  [PRIO_BITS-1:0]    left_prio_i,
  input  wire  [DATA_BITS-1:0]    left_data_i,
  input  wire  [PRIO_BITS-1:0]    right_prio_i,
  input  wire  [DATA_BITS-1:0]    right_data_i,
  output logic                    ge_o,
  output logic [PRIO_BITS-1:0]    prio_o,
  output logic [DATA_BITS-1:0]    data_o
);

  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic [DATA_BITS-1:0] data_q, data_d;

  // entries at least as high as the new one stay ahead of it
  assign ge_o = occupied_i && (prio_q >= new_prio_i);

  always_comb begin
    prio_d = prio_q;
    data_d = data_q;
    if (ctrl_i.en) begin
      if (ctrl_i.remove) begin
        prio_d = right_prio_i;
        data_d = right_data_i;
      end else if (!ge_o) begin
        if (left_ge_i) begin
          prio_d = new_prio_i;
          data_d = new_data_i;
        end else begin
          prio_d = left_prio_i;
          data_d = left_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign prio_o = prio_q;
  assign data_o = data_q;

endmodule : spq_cell
`default_nettype wire
